// ===== sv/bblc_pkg.sv =====
// ----------------------------------------------------------------------------
// bblc_pkg
// Types and constants shared by the byte budget lru cache modules.
// ----------------------------------------------------------------------------
package bblc_pkg;

	localparam int ENTRIES_DEF = 32;

	typedef logic [2:0] status_t;

	localparam status_t ST_STORED  = 3'd0;
	localparam status_t ST_UPDATED = 3'd1;
	localparam status_t ST_IGNORED = 3'd2;
	localparam status_t ST_TOO_BIG = 3'd3;
	localparam status_t ST_HIT     = 3'd4;
	localparam status_t ST_MISS    = 3'd5;
	localparam status_t ST_EVICTED = 3'd6;

	localparam logic KIND_LOOKUP = 1'b0;

	typedef struct packed {
		logic        kind;
		logic [31:0] key;
		logic [31:0] data_handle;
		logic [31:0] data_size;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] key_out;
		logic [31:0] handle_out;
		logic [31:0] size_out;
		logic [31:0] used_bytes;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [31:0] bytes;
	} slot_data_t;

endpackage

// ===== sv/bblc_store.sv =====
// ----------------------------------------------------------------------------
// bblc_store
// Handle and byte size store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bblc_store import bblc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int AW      = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  slot_data_t        wr_data,
	input  logic [AW-1:0]     rd_addr,
	output slot_data_t        rd_data
);

	slot_data_t mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/byte_budget_lru_cache.sv =====
// ----------------------------------------------------------------------------
// byte_budget_lru_cache
// Fully associative lru cache index that keeps its held bytes under a limit.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high until its final result
// beat has been loaded into the output register. A lookup, an ignored or
// rejected insert, or an update without size change steps through tag
// compare with store read, then result, and its beat is registered by the
// result step. A new entry or a size change adds a finishing step, and
// before it, per eviction, victim select with store read, then the
// eviction beat. Output stalls can hold the result, finishing and eviction
// steps. Tags and ranks compare in parallel; handles and sizes sit in a
// store with one write and one read port.
module byte_budget_lru_cache import bblc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(ENTRIES);
	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOOK  = 6'b000010,
		S_READ  = 6'b000100,
		S_EVSEL = 6'b001000,
		S_EVICT = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [31:0]       limit_q;
	logic [31:0]       used_q;
	logic [CW-1:0]     cnt_q;
	logic [ENTRIES-1:0] valid_q;
	logic [31:0]       key_q  [ENTRIES];
	logic [RW-1:0]     rank_q [ENTRIES];
	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	logic              upd_q;
	logic [AW-1:0]     vic_idx_q;
	logic [RW-1:0]     vic_rank_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              hit_c;
	logic [AW-1:0]     hit_idx_c;
	logic [AW-1:0]     vic_idx_c;
	logic [AW-1:0]     free_idx_c;
	logic [RW-1:0]     tgt_rank_c;
	logic [RW-1:0]     hit_rank_c;
	logic              over_c;
	logic              lru_ok_c;
	logic              need_ev_c;
	logic              can_emit;
	logic              ins_ok_c;
	logic              same_c;
	logic              out_load_c;
	logic [31:0]       used_less_c;
	logic [31:0]       used_evict_c;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	slot_data_t        mem_wdata;
	logic [AW-1:0]     mem_raddr;
	slot_data_t        mem_rdata;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign can_emit  = !out_valid_q || !out_stall;

	always_comb begin
		hit_c      = 1'b0;
		hit_idx_c  = '0;
		vic_idx_c  = '0;
		free_idx_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == req_q.key) begin
				hit_c     = 1'b1;
				hit_idx_c = AW'(i);
			end
			if (!valid_q[i]) begin
				free_idx_c = AW'(i);
			end
			if (valid_q[i] && rank_q[i] == tgt_rank_c) begin
				vic_idx_c = AW'(i);
			end
		end
	end

	assign hit_rank_c = rank_q[hit_idx_q];

	always_comb begin
		tgt_rank_c = RW'(cnt_q - CW'(1));
		if (upd_q && hit_rank_c == tgt_rank_c) begin
			tgt_rank_c = RW'(cnt_q - CW'(2));
		end
	end

	assign over_c    = ({1'b0, req_q.data_size} + {1'b0, used_q}) > {1'b0, limit_q};
	assign lru_ok_c  = upd_q ? (cnt_q > CW'(1)) : (cnt_q != '0);
	assign need_ev_c = (over_c && lru_ok_c) || (!upd_q && cnt_q == CW'(ENTRIES));

	assign ins_ok_c = req_q.kind != KIND_LOOKUP && req_q.key != '0 &&
		req_q.data_handle != '0 && limit_q != '0 &&
		req_q.data_size <= (limit_q >> 1);
	assign same_c   = hit_q && mem_rdata.bytes == req_q.data_size;

	assign out_load_c = can_emit && ((state_q == S_READ && !(ins_ok_c && !same_c)) ||
		(state_q == S_EVSEL && !need_ev_c) || state_q == S_EVICT);

	assign used_less_c  = (used_q >= mem_rdata.bytes) ? used_q - mem_rdata.bytes : '0;
	assign used_evict_c = used_less_c;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = '{handle: req_q.data_handle, bytes: req_q.data_size};
		if (state_q == S_READ && ins_ok_c && same_c && can_emit) begin
			mem_we = 1'b1;
		end
		if (state_q == S_EVSEL && !need_ev_c && can_emit) begin
			mem_we    = 1'b1;
			mem_waddr = upd_q ? hit_idx_q : free_idx_c;
		end
	end

	always_comb begin
		mem_raddr = vic_idx_q;
		if (state_q == S_LOOK) begin
			mem_raddr = hit_idx_c;
		end else if (state_q == S_READ) begin
			mem_raddr = hit_idx_q;
		end else if (state_q == S_EVSEL) begin
			mem_raddr = vic_idx_c;
		end
	end

	bblc_store #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= '0;
			used_q      <= '0;
			cnt_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			upd_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q     <= hit_c;
					hit_idx_q <= hit_idx_c;
					state_q   <= S_READ;
				end
				S_READ: begin
					if (can_emit) begin
						out_q.key_out    <= req_q.key;
						out_q.handle_out <= '0;
						out_q.size_out   <= '0;
						out_q.used_bytes <= used_q;
						out_q.last       <= 1'b1;
						state_q          <= S_IDLE;
						if (req_q.kind == KIND_LOOKUP) begin
							if (hit_q) begin
								out_q.status     <= ST_HIT;
								out_q.handle_out <= mem_rdata.handle;
								for (int i = 0; i < ENTRIES; i++) begin
									if (valid_q[i] && rank_q[i] < hit_rank_c) begin
										rank_q[i] <= rank_q[i] + RW'(1);
									end
								end
								rank_q[hit_idx_q] <= '0;
							end else begin
								out_q.status <= ST_MISS;
							end
						end else if (req_q.key == '0 || req_q.data_handle == '0 ||
						             limit_q == '0) begin
							out_q.status <= ST_IGNORED;
						end else if (req_q.data_size > (limit_q >> 1)) begin
							out_q.status <= ST_TOO_BIG;
						end else if (same_c) begin
							out_q.status <= ST_UPDATED;
							for (int i = 0; i < ENTRIES; i++) begin
								if (valid_q[i] && rank_q[i] < hit_rank_c) begin
									rank_q[i] <= rank_q[i] + RW'(1);
								end
							end
							rank_q[hit_idx_q] <= '0;
						end else begin
							upd_q <= hit_q;
							if (hit_q) begin
								used_q <= used_less_c;
							end
							state_q <= S_EVSEL;
						end
					end
				end
				S_EVSEL: begin
					if (need_ev_c) begin
						vic_idx_q  <= vic_idx_c;
						vic_rank_q <= tgt_rank_c;
						state_q    <= S_EVICT;
					end else if (can_emit) begin
						out_q.key_out    <= req_q.key;
						out_q.handle_out <= '0;
						out_q.size_out   <= '0;
						out_q.used_bytes <= used_q + req_q.data_size;
						out_q.last       <= 1'b1;
						used_q           <= used_q + req_q.data_size;
						state_q          <= S_IDLE;
						if (upd_q) begin
							out_q.status <= ST_UPDATED;
							for (int i = 0; i < ENTRIES; i++) begin
								if (valid_q[i] && rank_q[i] < hit_rank_c) begin
									rank_q[i] <= rank_q[i] + RW'(1);
								end
							end
							rank_q[hit_idx_q] <= '0;
						end else begin
							out_q.status <= ST_STORED;
							for (int i = 0; i < ENTRIES; i++) begin
								if (valid_q[i]) begin
									rank_q[i] <= rank_q[i] + RW'(1);
								end
							end
							valid_q[free_idx_c] <= 1'b1;
							key_q[free_idx_c]   <= req_q.key;
							rank_q[free_idx_c]  <= '0;
							cnt_q               <= cnt_q + CW'(1);
						end
					end
				end
				S_EVICT: begin
					if (can_emit) begin
						out_q.status     <= ST_EVICTED;
						out_q.key_out    <= key_q[vic_idx_q];
						out_q.handle_out <= mem_rdata.handle;
						out_q.size_out   <= mem_rdata.bytes;
						out_q.used_bytes <= used_evict_c;
						out_q.last       <= 1'b0;
						used_q           <= used_evict_c;
						valid_q[vic_idx_q] <= 1'b0;
						cnt_q            <= cnt_q - CW'(1);
						for (int i = 0; i < ENTRIES; i++) begin
							if (valid_q[i] && rank_q[i] > vic_rank_q) begin
								rank_q[i] <= rank_q[i] - RW'(1);
							end
						end
						state_q <= S_EVSEL;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ENTRIES))
		else $error("entry count above table size");

	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("entry count disagrees with valid bits");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_LOOK)
		else $error("accepted beat did not start tag compare");

endmodule
